// ===== sv/espb_pkg.sv =====
// Package with the types, constants and codes of the send plan builder.
package espb_pkg;

  localparam int NODES     = 16;
  localparam int EXPORTS   = 1024;
  localparam int AW        = 10;
  localparam int CW        = 11;
  localparam int DW        = 5;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_SLOT    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_OWN_NODE   = 1'b1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREFIX = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_QUERY  = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [7:0] dest_id;
    logic [9:0]        slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  node_id;
    logic [9:0]  start_res;
    logic [10:0] length;
    logic [9:0]  export_index;
    logic        self_message;
    logic [4:0]  send_count;
    logic [10:0] max_send_length;
    logic        needs_buffer;
    logic        last;
  } out_item_t;

endpackage

// ===== sv/espb_ram.sv =====
// Simple dual-port synchronous memory with a registered read.
module espb_ram #(
  parameter int WIDTH = espb_pkg::DW,
  parameter int DEPTH = espb_pkg::EXPORTS,
  parameter int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/export_send_plan_builder.sv =====
// Top level of the send plan builder: load, finish and query sequencing.
// A load and an error answer are registered at their transfer; a slot answer in the cycle after it.
// A finish of an ungrouped set runs a prefix pass over the nodes and a scan of the loaded exports,
// then a descriptor for each node with exports and the summary, each held while the output stalls.
// One item is in work at a time; the next transfer waits until its last result is taken.
// Reset is synchronous and clears counters and flags; the two memories are undefined until written.
module export_send_plan_builder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  espb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output espb_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_wdata
);

  logic [2:0]  state_r;
  logic [4:0]  node_count_r;
  logic [3:0]  own_node_r;
  logic [10:0] cnt_r [espb_pkg::NODES];
  logic [10:0] off_r [espb_pkg::NODES];
  logic [10:0] cur_r [espb_pkg::NODES];
  logic [10:0] export_total_r;
  logic [10:0] active_total_r;
  logic signed [7:0] prev_r;
  logic        ng_r;
  logic        bad_r;
  logic        done_r;
  logic [3:0]  pn_r;
  logic [10:0] acc_r;
  logic [10:0] scan_i_r;
  logic        pend_r;
  logic [9:0]  pend_idx_r;
  logic [4:0]  emit_n_r;
  logic        self_r;
  logic [4:0]  sends_r;
  logic [10:0] maxlen_r;
  logic        out_valid_r;
  espb_pkg::out_item_t out_r;

  logic        acc_in;
  logic        ld_neg;
  logic [3:0]  ld_n;
  logic [4:0]  limit;
  logic        ld_bad_id;
  logic        eff_bad;
  logic        eff_ng;
  logic [10:0] eff_tot;
  logic [10:0] eff_cnt;
  logic [10:0] eff_act;
  logic signed [7:0] eff_prev;
  logic        ld_ok;
  logic        ld_store;
  logic        ld_cnt_we;
  logic        q_ok;
  logic        out_free;
  logic        scan_issue;
  logic [4:0]  dest_rd;
  logic [9:0]  slot_rd;
  logic        dest_we;
  logic        slot_we;
  logic [9:0]  slot_raddr;
  logic [10:0] scan_cur;
  logic [10:0] emit_len;
  logic        out_load;
  espb_pkg::out_item_t out_nxt;

  assign in_ready  = (state_r == espb_pkg::ST_IDLE) && !out_valid_r;
  assign acc_in    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    ld_neg    = in_data.dest_id[7];
    ld_n      = in_data.dest_id[3:0];
    limit     = (node_count_r > 5'(espb_pkg::NODES)) ? 5'(espb_pkg::NODES) : node_count_r;
    ld_bad_id = !ld_neg && ({1'b0, in_data.dest_id[6:0]} >= {3'b0, limit});
    eff_bad   = done_r ? 1'b0 : bad_r;
    eff_ng    = done_r ? 1'b0 : ng_r;
    eff_tot   = done_r ? 11'd0 : export_total_r;
    eff_cnt   = done_r ? 11'd0 : cnt_r[ld_n];
    eff_act   = done_r ? 11'd0 : active_total_r;
    eff_prev  = done_r ? -8'sd1 : prev_r;
    ld_ok     = !eff_bad && (eff_tot < 11'(espb_pkg::EXPORTS));
    ld_store  = ld_ok && !ld_bad_id;
    ld_cnt_we = ld_store && !ld_neg;
    q_ok      = done_r && !bad_r && ng_r && ({1'b0, in_data.slot_index} < active_total_r);
    scan_issue = scan_i_r < export_total_r;
    scan_cur  = cur_r[dest_rd[3:0]];
    emit_len  = cnt_r[emit_n_r[3:0]];
  end

  always_comb begin
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (state_r)
      espb_pkg::ST_IDLE: begin
        if (acc_in && (in_data.opcode == espb_pkg::OP_FINISH) && bad_r) begin
          out_load     = 1'b1;
          out_nxt.kind = espb_pkg::KIND_ERROR;
          out_nxt.last = 1'b1;
        end else if (acc_in && (in_data.opcode == espb_pkg::OP_QUERY) && !q_ok) begin
          out_load     = 1'b1;
          out_nxt.kind = espb_pkg::KIND_ERROR;
        end
      end
      espb_pkg::ST_EMIT: begin
        if (out_free) begin
          if (emit_n_r == 5'(espb_pkg::NODES)) begin
            out_load                = 1'b1;
            out_nxt.kind            = espb_pkg::KIND_SUMMARY;
            out_nxt.self_message    = self_r;
            out_nxt.send_count      = sends_r;
            out_nxt.max_send_length = maxlen_r;
            out_nxt.needs_buffer    = ng_r;
            out_nxt.last            = 1'b1;
          end else if (emit_len != '0) begin
            out_load          = 1'b1;
            out_nxt.kind      = espb_pkg::KIND_DESC;
            out_nxt.node_id   = emit_n_r[3:0];
            out_nxt.start_res = off_r[emit_n_r[3:0]][9:0];
            out_nxt.length    = emit_len;
          end
        end
      end
      espb_pkg::ST_QUERY: begin
        out_load             = 1'b1;
        out_nxt.kind         = espb_pkg::KIND_SLOT;
        out_nxt.export_index = slot_rd;
      end
      default: ;
    endcase
  end

  assign dest_we    = acc_in && (in_data.opcode == espb_pkg::OP_LOAD) && ld_store;
  assign slot_we    = (state_r == espb_pkg::ST_SCAN) && pend_r && !dest_rd[4] &&
                      (scan_cur < 11'(espb_pkg::EXPORTS));
  assign slot_raddr = in_data.slot_index;

  espb_ram #(.WIDTH(espb_pkg::DW), .DEPTH(espb_pkg::EXPORTS)) u_dest (
    .clk   (clk),
    .we    (dest_we),
    .waddr (eff_tot[9:0]),
    .wdata ({ld_neg, ld_n}),
    .raddr (scan_i_r[9:0]),
    .rdata (dest_rd)
  );

  espb_ram #(.WIDTH(espb_pkg::AW), .DEPTH(espb_pkg::EXPORTS)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (scan_cur[9:0]),
    .wdata (pend_idx_r),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= espb_pkg::ST_IDLE;
      node_count_r   <= 5'd16;
      own_node_r     <= 4'd0;
      for (int k = 0; k < espb_pkg::NODES; k++) begin
        cnt_r[k] <= '0;
        off_r[k] <= '0;
      end
      export_total_r <= '0;
      active_total_r <= '0;
      prev_r         <= -8'sd1;
      ng_r           <= 1'b0;
      bad_r          <= 1'b0;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      pend_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          espb_pkg::REG_NODE_COUNT: node_count_r <= cfg_wdata;
          espb_pkg::REG_OWN_NODE:   own_node_r   <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_r       <= out_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        espb_pkg::ST_IDLE: begin
          if (acc_in) begin
            case (in_data.opcode)
              espb_pkg::OP_LOAD: begin
                for (int k = 0; k < espb_pkg::NODES; k++) begin
                  if (ld_cnt_we && (ld_n == 4'(k))) begin
                    cnt_r[k] <= eff_cnt + 11'd1;
                    if (eff_cnt == '0) begin
                      off_r[k] <= eff_tot;
                    end
                  end else if (done_r) begin
                    cnt_r[k] <= '0;
                    off_r[k] <= '0;
                  end
                end
                export_total_r <= ld_store ? eff_tot + 11'd1 : eff_tot;
                active_total_r <= ld_cnt_we ? eff_act + 11'd1 : eff_act;
                prev_r         <= ld_store ? in_data.dest_id : eff_prev;
                ng_r           <= eff_ng || (ld_cnt_we && (eff_cnt != '0) &&
                                             (in_data.dest_id != eff_prev));
                bad_r          <= eff_bad || (ld_ok && ld_bad_id);
                done_r         <= 1'b0;
              end
              espb_pkg::OP_FINISH: begin
                done_r   <= 1'b1;
                emit_n_r <= '0;
                self_r   <= 1'b0;
                sends_r  <= '0;
                maxlen_r <= '0;
                if (!bad_r) begin
                  if (ng_r) begin
                    state_r <= espb_pkg::ST_PREFIX;
                    pn_r    <= '0;
                    acc_r   <= '0;
                  end else begin
                    state_r <= espb_pkg::ST_EMIT;
                  end
                end
              end
              espb_pkg::OP_QUERY: begin
                if (q_ok) begin
                  state_r <= espb_pkg::ST_QUERY;
                end
              end
              default: ;
            endcase
          end
        end
        espb_pkg::ST_PREFIX: begin
          off_r[pn_r] <= acc_r;
          cur_r[pn_r] <= acc_r;
          acc_r       <= acc_r + cnt_r[pn_r];
          pn_r        <= pn_r + 4'd1;
          if (pn_r == 4'(espb_pkg::NODES - 1)) begin
            state_r  <= espb_pkg::ST_SCAN;
            scan_i_r <= '0;
            pend_r   <= 1'b0;
          end
        end
        espb_pkg::ST_SCAN: begin
          if (pend_r && !dest_rd[4]) begin
            cur_r[dest_rd[3:0]] <= scan_cur + 11'd1;
          end
          pend_r     <= scan_issue;
          pend_idx_r <= scan_i_r[9:0];
          if (scan_issue) begin
            scan_i_r <= scan_i_r + 11'd1;
          end else if (!pend_r) begin
            state_r <= espb_pkg::ST_EMIT;
          end
        end
        espb_pkg::ST_EMIT: begin
          if (out_free) begin
            if (emit_n_r == 5'(espb_pkg::NODES)) begin
              state_r <= espb_pkg::ST_IDLE;
            end else begin
              emit_n_r <= emit_n_r + 5'd1;
              if (emit_len != '0) begin
                if (emit_n_r[3:0] == own_node_r) begin
                  self_r <= 1'b1;
                end else begin
                  sends_r <= sends_r + 5'd1;
                  if (emit_len > maxlen_r) begin
                    maxlen_r <= emit_len;
                  end
                end
              end
            end
          end
        end
        espb_pkg::ST_QUERY: begin
          state_r <= espb_pkg::ST_IDLE;
        end
        default: state_r <= espb_pkg::ST_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |-> (state_r == espb_pkg::ST_IDLE))
    else $error("Input transfer taken outside the idle state.");

  a_no_out_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == espb_pkg::ST_PREFIX || state_r == espb_pkg::ST_SCAN) |-> !out_valid_r)
    else $error("Result pending during the prefix or scan pass.");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    export_total_r <= 11'(espb_pkg::EXPORTS))
    else $error("Export total beyond the store depth.");

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_total_r <= export_total_r)
    else $error("Active total exceeds export total.");

endmodule
